// ----- src/crfl_pkg.sv -----
// crfl_pkg: shared constants, codes and cell control type for the
// replacement-policy cache. No dependencies.
`timescale 1ns / 1ps

package crfl_pkg;

  // default built depth of the cell chain
  localparam int DEFAULT_MAX_ENTRIES = 16;

  // field widths
  localparam int KEY_W      = 8;
  localparam int POL_W      = 2;
  localparam int CAP_W      = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // replacement policy codes (any other code behaves as fifo)
  localparam logic [POL_W-1:0] POL_FIFO  = 2'd0;
  localparam logic [POL_W-1:0] POL_LRU   = 2'd1;
  localparam logic [POL_W-1:0] POL_CLOCK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_POLICY   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CAPACITY = 1'd1;

  // per-cell update commands
  typedef struct packed {
    logic shift;    // take slot, key and ref bit from the left neighbor
    logic replace;  // overwrite key in place, clear ref bit
    logic set_ref;  // mark as referenced
    logic clr_ref;  // second chance used up
  } cell_ctrl_t;

endpackage

// ----- src/cache_replacement_fifo_lru_clock.sv -----
// Fully associative byte-key cache with fifo, lru or clock replacement.
// The access key is registered, then a compare-and-update over the cell chain writes the
// result register; no new key is taken until that update is done, and it waits for a free output.
// A finished result waits in the output register while the next key is taken.
// Reset (synchronous): empty cache, identity recency order, clear reference bits,
// hand at slot 0, policy fifo, capacity 16; keys hold anything until written.
`timescale 1ns / 1ps

module cache_replacement_fifo_lru_clock #(
  parameter int MAX_ENTRIES = crfl_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                             clk,
  input  logic                             rst,
  // access stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [crfl_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] access_key
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [crfl_pkg::OUT_TDATA_W-1:0] m_tdata,   // [0] hit, [1] evicted, [9:2] evicted_key
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [crfl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [crfl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W  = crfl_pkg::KEY_W;

  // control and configuration registers
  logic                       busy;
  logic [KEY_W-1:0]           key_r;
  logic [crfl_pkg::POL_W-1:0] policy;
  logic [crfl_pkg::CAP_W-1:0] capacity;
  logic [OCC_W-1:0]           occ;
  logic [SLOT_W-1:0]          hand;
  logic                       out_valid;
  logic                       out_hit;
  logic                       out_evicted;
  logic [KEY_W-1:0]           out_evicted_key;

  // chain signals
  crfl_pkg::cell_ctrl_t       ctrl [MAX_ENTRIES];
  logic [SLOT_W-1:0]          slot_q [MAX_ENTRIES];
  logic [KEY_W-1:0]           key_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]     ref_q;
  logic [MAX_ENTRIES-1:0]     match_q;
  logic [SLOT_W-1:0]          left_slot [MAX_ENTRIES];
  logic [KEY_W-1:0]           left_key [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]     left_ref;
  logic [MAX_ENTRIES-1:0]     resident;
  logic [MAX_ENTRIES-1:0]     hand_match;

  // decision signals
  logic                       go;
  logic                       lru;
  logic                       clk_pol;
  logic [OCC_W-1:0]           cap_eff;
  logic                       full;
  logic                       any_hit;
  logic [SLOT_W-1:0]          hit_pos;
  logic [SLOT_W-1:0]          last_pos;
  logic                       do_shift;
  logic                       do_replace;
  logic [SLOT_W-1:0]          shift_pos;
  logic [SLOT_W-1:0]          victim;
  logic [MAX_ENTRIES-1:0]     clr_mask;
  logic [SLOT_W-1:0]          next_hand_pos;
  logic [SLOT_W-1:0]          front_slot;
  logic                       front_ref;
  logic [KEY_W-1:0]           victim_key;
  logic [KEY_W-1:0]           oldest_key;
  logic [SLOT_W-1:0]          next_hand_slot;

  assign s_tready  = !busy;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {6'b0, out_evicted_key, out_evicted, out_hit};

  assign go      = busy && (!out_valid || m_tready);
  assign lru     = (policy == crfl_pkg::POL_LRU);
  assign clk_pol = (policy == crfl_pkg::POL_CLOCK);

  // capacity clamped to the built depth, at least one
  always_comb begin
    if (capacity == '0) begin
      cap_eff = OCC_W'(1);
    end else if (int'(capacity) > MAX_ENTRIES) begin
      cap_eff = OCC_W'(MAX_ENTRIES);
    end else begin
      cap_eff = OCC_W'(capacity);
    end
  end

  assign full     = (occ >= cap_eff);
  assign last_pos = SLOT_W'(occ - 1'b1);

  // resident positions and hand lookup
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      resident[i]   = (i < int'(occ));
      hand_match[i] = resident[i] && (slot_q[i] == hand);
    end
  end

  // first matching position
  always_comb begin
    any_hit = 1'b0;
    hit_pos = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!any_hit && match_q[i]) begin
        any_hit = 1'b1;
        hit_pos = SLOT_W'(i);
      end
    end
  end

  crfl_sweep #(
    .N      (MAX_ENTRIES),
    .SLOT_W (SLOT_W)
  ) u_sweep (
    .resident   (resident),
    .ref_bits   (ref_q),
    .hand_match (hand_match),
    .last_pos   (last_pos),
    .victim     (victim),
    .clr_mask   (clr_mask)
  );

  // kind of update this access makes
  always_comb begin
    do_shift   = any_hit ? lru : !(full && clk_pol);
    do_replace = !any_hit && full && clk_pol;
    if (any_hit) begin
      shift_pos = hit_pos;
    end else if (full) begin
      shift_pos = last_pos;
    end else begin
      shift_pos = SLOT_W'(occ);
    end
    next_hand_pos = (victim == '0) ? last_pos : SLOT_W'(victim - 1'b1);
  end

  // gather from the chain by position
  always_comb begin
    front_slot     = '0;
    front_ref      = 1'b0;
    victim_key     = '0;
    oldest_key     = '0;
    next_hand_slot = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (SLOT_W'(i) == shift_pos) begin
        front_slot = slot_q[i];
        front_ref  = ref_q[i] && any_hit;
      end
      if (SLOT_W'(i) == victim) begin
        victim_key = key_q[i];
      end
      if (SLOT_W'(i) == last_pos) begin
        oldest_key = key_q[i];
      end
      if (SLOT_W'(i) == next_hand_pos) begin
        next_hand_slot = slot_q[i];
      end
    end
  end

  // per-cell commands and neighbor links
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctrl[i].shift   = go && do_shift && (SLOT_W'(i) <= shift_pos);
      ctrl[i].replace = go && do_replace && (SLOT_W'(i) == victim);
      ctrl[i].set_ref = go && any_hit && clk_pol && (SLOT_W'(i) == hit_pos);
      ctrl[i].clr_ref = go && do_replace && clr_mask[i];
      if (i == 0) begin
        left_slot[i] = front_slot;
        left_key[i]  = key_r;
        left_ref[i]  = front_ref;
      end else begin
        left_slot[i] = slot_q[i-1];
        left_key[i]  = key_q[i-1];
        left_ref[i]  = ref_q[i-1];
      end
    end
  end

  // the chain of recency cells, position 0 newest
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    crfl_cell #(
      .SLOT_W (SLOT_W),
      .INDEX  (g)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl[g]),
      .resident   (resident[g]),
      .access_key (key_r),
      .left_slot  (left_slot[g]),
      .left_key   (left_key[g]),
      .left_ref   (left_ref[g]),
      .slot       (slot_q[g]),
      .key        (key_q[g]),
      .ref_bit    (ref_q[g]),
      .match      (match_q[g])
    );
  end

  // control state, configuration and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      policy    <= crfl_pkg::POL_FIFO;
      capacity  <= crfl_pkg::CAP_W'(16);
      occ       <= '0;
      hand      <= '0;
    end else begin
      // configuration transaction
      if (cfg_valid) begin
        case (cfg_addr)
          crfl_pkg::REG_POLICY:   policy   <= cfg_data[crfl_pkg::POL_W-1:0];
          crfl_pkg::REG_CAPACITY: capacity <= cfg_data[crfl_pkg::CAP_W-1:0];
          default: ;
        endcase
      end
      // input transaction
      if (s_tvalid && !busy) begin
        busy <= 1'b1;
      end
      // update cycle
      if (go) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        if (!any_hit && !full) begin
          occ <= OCC_W'(occ + 1'b1);
          if (clk_pol && (occ == '0)) begin
            hand <= front_slot;
          end
        end
        if (do_replace) begin
          hand <= next_hand_slot;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && !busy) begin
      key_r <= s_tdata[KEY_W-1:0];
    end
    if (go) begin
      out_hit     <= any_hit;
      out_evicted <= !any_hit && full;
      if (any_hit || !full) begin
        out_evicted_key <= '0;
      end else if (clk_pol) begin
        out_evicted_key <= victim_key;
      end else begin
        out_evicted_key <= oldest_key;
      end
    end
  end

endmodule

// ----- src/crfl_cell.sv -----
// crfl_cell: one recency position of the cache chain, holding slot number,
// key and reference bit. Depends on crfl_pkg.
`timescale 1ns / 1ps

module crfl_cell #(
  parameter int SLOT_W = 4,
  parameter int INDEX  = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  crfl_pkg::cell_ctrl_t      ctrl,
  input  logic                      resident,
  input  logic [crfl_pkg::KEY_W-1:0] access_key,
  input  logic [SLOT_W-1:0]         left_slot,
  input  logic [crfl_pkg::KEY_W-1:0] left_key,
  input  logic                      left_ref,
  output logic [SLOT_W-1:0]         slot,
  output logic [crfl_pkg::KEY_W-1:0] key,
  output logic                      ref_bit,
  output logic                      match
);

  // key compare against the access in flight
  assign match = resident && (key == access_key);

  // slot number and reference bit
  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= SLOT_W'(INDEX);
      ref_bit <= 1'b0;
    end else if (ctrl.shift) begin
      slot    <= left_slot;
      ref_bit <= left_ref;
    end else if (ctrl.replace) begin
      ref_bit <= 1'b0;
    end else if (ctrl.set_ref) begin
      ref_bit <= 1'b1;
    end else if (ctrl.clr_ref) begin
      ref_bit <= 1'b0;
    end
  end

  // key payload, no reset
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key <= left_key;
    end else if (ctrl.replace) begin
      key <= access_key;
    end
  end

endmodule

// ----- src/crfl_sweep.sv -----
// crfl_sweep: clock-hand victim search over the chain's reference bits,
// with the mask of bits cleared on the way. Depends on nothing else.
`timescale 1ns / 1ps

module crfl_sweep #(
  parameter int N      = 16,
  parameter int SLOT_W = 4
) (
  input  logic [N-1:0]      resident,
  input  logic [N-1:0]      ref_bits,
  input  logic [N-1:0]      hand_match,
  input  logic [SLOT_W-1:0] last_pos,
  output logic [SLOT_W-1:0] victim,
  output logic [N-1:0]      clr_mask
);

  logic [SLOT_W-1:0] hand_pos;
  logic              hand_found;
  logic              lo_ok;
  logic [SLOT_W-1:0] lo_pos;
  logic              hi_ok;
  logic [SLOT_W-1:0] hi_pos;

  // hand position in age order, oldest entry if the hand is not resident
  always_comb begin
    hand_pos   = last_pos;
    hand_found = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (!hand_found && hand_match[i]) begin
        hand_pos   = SLOT_W'(i);
        hand_found = 1'b1;
      end
    end
  end

  // nearest clear bit at the hand or newer than it, then after wrap from the oldest end
  always_comb begin
    lo_ok  = 1'b0;
    lo_pos = '0;
    hi_ok  = 1'b0;
    hi_pos = '0;
    for (int i = 0; i < N; i++) begin
      if (resident[i] && !ref_bits[i]) begin
        if (SLOT_W'(i) <= hand_pos) begin
          lo_ok  = 1'b1;
          lo_pos = SLOT_W'(i);
        end else begin
          hi_ok  = 1'b1;
          hi_pos = SLOT_W'(i);
        end
      end
    end
  end

  // victim and cleared reference bits
  always_comb begin
    victim   = hand_pos;
    clr_mask = resident;
    if (lo_ok) begin
      victim = lo_pos;
      for (int i = 0; i < N; i++) begin
        clr_mask[i] = resident[i] && (SLOT_W'(i) >= lo_pos) && (SLOT_W'(i) <= hand_pos);
      end
    end else if (hi_ok) begin
      victim = hi_pos;
      for (int i = 0; i < N; i++) begin
        clr_mask[i] = resident[i] && ((SLOT_W'(i) <= hand_pos) || (SLOT_W'(i) >= hi_pos));
      end
    end
  end

endmodule

// ----- dv/tb.sv -----
// tb: self-checking testbench for the fifo / lru / clock replacement cache.
// Depends on src/crfl_pkg.sv and src/cache_replacement_fifo_lru_clock.sv; a scoreboard
// class mirrors the cache state and checks every result transaction in order.
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH       = crfl_pkg::DEFAULT_MAX_ENTRIES;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int KEY_W       = crfl_pkg::KEY_W;
  localparam int POL_W       = crfl_pkg::POL_W;
  localparam int CAP_W       = crfl_pkg::CAP_W;
  localparam int CFG_ADDR_W  = crfl_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W  = crfl_pkg::CFG_DATA_W;
  localparam int IN_TDATA_W  = crfl_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = crfl_pkg::OUT_TDATA_W;

  // undefined policy code, the cache treats it as fifo
  localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

  // result fields, lowest bit first: hit, evicted, evicted_key
  typedef struct packed {
    logic [KEY_W-1:0] evicted_key;
    logic             evicted;
    logic             hit;
  } access_result_t;

  // shadow copy of the cache plus the queue of results still owed
  class access_scoreboard;
    logic [KEY_W-1:0]  slot_key [DEPTH];
    logic [SLOT_W-1:0] age_order [DEPTH];  // position 0 is newest
    bit                ref_bit [DEPTH];
    int unsigned       fill;
    logic [SLOT_W-1:0] hand;
    logic [POL_W-1:0]  policy;
    logic [CAP_W-1:0]  capacity;
    access_result_t    owed_q[$];
    int unsigned       errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        slot_key[i]  = '0;
        age_order[i] = SLOT_W'(i);
        ref_bit[i]   = 1'b0;
      end
      fill     = 0;
      hand     = '0;
      policy   = crfl_pkg::POL_FIFO;
      capacity = CAP_W'(DEPTH);
      errors   = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void apply_write(logic [CFG_ADDR_W-1:0] idx,
                              logic [CFG_DATA_W-1:0] value);
      if (idx == crfl_pkg::REG_POLICY) policy = value[POL_W-1:0];
      else if (idx == crfl_pkg::REG_CAPACITY) capacity = value[CAP_W-1:0];
    endfunction

    // move the slot at age position p to the newest position
    function void to_front(int unsigned p);
      logic [SLOT_W-1:0] s;
      s = age_order[p];
      while (p > 0) begin
        age_order[p] = age_order[p-1];
        p--;
      end
      age_order[0] = s;
    endfunction

    function void note_access(logic [KEY_W-1:0] key);
      access_result_t    r;
      bit                is_lru, is_clock;
      int unsigned       lim, p, hp, step;
      logic [SLOT_W-1:0] s;
      r        = '0;
      is_lru   = (policy == crfl_pkg::POL_LRU);
      is_clock = (policy == crfl_pkg::POL_CLOCK);
      lim      = capacity;
      if (lim < 1) lim = 1;
      if (lim > DEPTH) lim = DEPTH;

      // lookup over resident entries
      for (p = 0; p < fill; p++) begin
        s = age_order[p];
        if (slot_key[s] == key) begin
          if (is_clock) ref_bit[s] = 1'b1;
          if (is_lru) to_front(p);
          r.hit = 1'b1;
          owed_q.push_back(r);
          return;
        end
      end

      // full cache: clock replaces in place, fifo and lru drop the oldest
      if (fill >= lim && fill > 0) begin
        if (is_clock) begin
          hp = fill - 1;
          for (p = 0; p < fill; p++) begin
            if (age_order[p] == hand) begin
              hp = p;
              break;
            end
          end
          for (step = 0; step <= fill; step++) begin
            s = age_order[hp];
            if (!ref_bit[s]) break;
            ref_bit[s] = 1'b0;
            hp = (hp > 0) ? hp - 1 : fill - 1;
          end
          s = age_order[hp];
          r.evicted     = 1'b1;
          r.evicted_key = slot_key[s];
          slot_key[s]   = key;
          ref_bit[s]    = 1'b0;
          hand = (hp > 0) ? age_order[hp-1] : age_order[fill-1];
          owed_q.push_back(r);
          return;
        end
        s = age_order[fill-1];
        r.evicted     = 1'b1;
        r.evicted_key = slot_key[s];
        fill--;
      end

      // insert as newest into the first free slot
      s           = age_order[fill];
      slot_key[s] = key;
      ref_bit[s]  = 1'b0;
      to_front(fill);
      fill++;
      if (is_clock && fill == 1) hand = s;
      owed_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      access_result_t got, want;
      got = tdata[$bits(access_result_t)-1:0];
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual tdata %h", $time, tdata);
        return;
      end
      want = owed_q.pop_front();
      if (got.hit !== want.hit) begin
        errors++;
        $display("%0t: hit mismatch, expected %0d actual %0d", $time, want.hit, got.hit);
      end
      if (got.evicted !== want.evicted) begin
        errors++;
        $display("%0t: evicted mismatch, expected %0d actual %0d",
                 $time, want.evicted, got.evicted);
      end
      if (got.evicted_key !== want.evicted_key) begin
        errors++;
        $display("%0t: evicted_key mismatch, expected %h actual %h",
                 $time, want.evicted_key, got.evicted_key);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  access_scoreboard sb;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;

  cache_replacement_fifo_lru_clock uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: random backpressure and in-order check
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one access transaction, with a random gap ahead of it
  task automatic push_access(input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    do @(posedge clk); while (!s_tready);
    sb.note_access(key);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_write(idx, value);
  endtask

  // both registers, in random order
  task automatic program_cache(input logic [POL_W-1:0] pol, input logic [CAP_W-1:0] cap);
    if ($urandom_range(1)) begin
      write_reg(crfl_pkg::REG_POLICY, CFG_DATA_W'(pol));
      write_reg(crfl_pkg::REG_CAPACITY, CFG_DATA_W'(cap));
    end else begin
      write_reg(crfl_pkg::REG_CAPACITY, CFG_DATA_W'(cap));
      write_reg(crfl_pkg::REG_POLICY, CFG_DATA_W'(pol));
    end
    cfg_valid <= 1'b0;
  endtask

  // stop sending and wait for every owed result, then a few more cycles
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] seq[$];
    logic [KEY_W-1:0] key_pool[$];
    logic [POL_W-1:0] pol_plan[12];
    logic [CAP_W-1:0] cap_plan[12];
    int unsigned      lim, pool_n;

    sb = new();
    pol_plan = '{crfl_pkg::POL_FIFO, crfl_pkg::POL_LRU, crfl_pkg::POL_CLOCK, POL_SPARE,
                 crfl_pkg::POL_CLOCK, crfl_pkg::POL_FIFO, POL_SPARE, crfl_pkg::POL_LRU,
                 crfl_pkg::POL_LRU, crfl_pkg::POL_CLOCK, crfl_pkg::POL_FIFO,
                 crfl_pkg::POL_CLOCK};
    cap_plan = '{5'd16, 5'd1, 5'd3, 5'd31, 5'd0, 5'd8, 5'd16, 5'd2,
                 5'd5, 5'd17, 5'd12, 5'd4};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // extreme keys and a hit from the reset setting (fifo, 16 entries)
    seq = {8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55};
    foreach (seq[i]) push_access(seq[i]);
    settle();

    // spare policy code, capacity under occupancy
    program_cache(POL_SPARE, 5'd2);
    seq = {8'h01, 8'h55, 8'h02, 8'h01};
    foreach (seq[i]) push_access(seq[i]);
    settle();

    // lru with capacity zero
    program_cache(crfl_pkg::POL_LRU, 5'd0);
    seq = {8'h02, 8'h03, 8'h03, 8'h04, 8'h02};
    foreach (seq[i]) push_access(seq[i]);
    settle();

    // clock sweep over set and clear reference bits
    program_cache(crfl_pkg::POL_CLOCK, 5'd3);
    seq = {8'h04, 8'h02, 8'h10, 8'h04, 8'h11, 8'h12, 8'h04, 8'h13};
    foreach (seq[i]) push_access(seq[i]);
    settle();

    // capacity above the built depth
    program_cache(crfl_pkg::POL_CLOCK, 5'd31);
    seq = {8'h20, 8'h21, 8'h20};
    foreach (seq[i]) push_access(seq[i]);
    settle();

    // random phases: each idle mode gets four settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph / 4)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 85;
        end
        1: begin
          send_idle_pct = 85;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      program_cache(pol_plan[ph], cap_plan[ph]);

      // working set a bit above capacity so hits and evictions mix
      lim = cap_plan[ph];
      if (lim < 1) lim = 1;
      if (lim > DEPTH) lim = DEPTH;
      pool_n = lim + $urandom_range(4);
      key_pool.delete();
      repeat (pool_n) key_pool.push_back(KEY_W'($urandom_range(255)));

      repeat (80) begin
        if ($urandom_range(99) < 75)
          push_access(key_pool[$urandom_range(pool_n - 1)]);
        else
          push_access(KEY_W'($urandom_range(255)));
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
